[rtl/segc_pkg.sv]
package segc_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned GRAD_W     = 11;
  localparam int unsigned MAG_W      = 10;
  localparam int unsigned SQ_W       = 20;
  localparam int unsigned SUMSQ_W    = 21;
  localparam int unsigned LIM_W      = 11;
  localparam int unsigned LIMSQ_W    = 22;
  localparam int unsigned DARK_W     = 9;
  localparam int unsigned GLYPH_W    = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned FIVE_SQ_W  = 23;
  localparam int unsigned QUAD_W     = 40;
  localparam int unsigned WIDE_W     = 46;
  localparam int unsigned SCALED_W   = 15;

  localparam logic [LIM_W-1:0]  EDGE_LIMIT_RESET = 11'd400;
  localparam logic [DARK_W-1:0] DARK_LIMIT_RESET = 9'd96;

  localparam int unsigned LUMA_SCALE   = 100;
  localparam int unsigned LUMA_DIVISOR = 2833;
  localparam int unsigned LUMA_LEVELS  = 10;

  localparam logic [GLYPH_W-1:0] GLYPH_HORIZONTAL = 4'd10;
  localparam logic [GLYPH_W-1:0] GLYPH_BACKSLASH  = 4'd11;
  localparam logic [GLYPH_W-1:0] GLYPH_VERTICAL   = 4'd12;
  localparam logic [GLYPH_W-1:0] GLYPH_SLASH      = 4'd13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_LIMIT = 8'd0,
    REG_DARK_LIMIT = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] top_left;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] bottom_left;
    logic [PIX_W-1:0] bottom;
    logic [PIX_W-1:0] bottom_right;
    logic             on_border;
  } window_t;

  // Flags that ride alongside the arithmetic through stages 1 to 4.
  typedef struct packed {
    logic [GLYPH_W-1:0] luma;
    logic               qual;
    logic               gx_neg;
    logic               gy_neg;
    logic               gx_zero;
    logic               gy_zero;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } front_t;

  // Luminance level centre*100/2833, found by counting the thresholds passed.
  function automatic logic [GLYPH_W-1:0] luma_level(input logic [PIX_W-1:0] c);
    logic [SCALED_W-1:0] scaled;
    logic [GLYPH_W-1:0]  lvl;
    scaled = SCALED_W'(c) * SCALED_W'(LUMA_SCALE);
    lvl    = '0;
    for (int k = 1; k < LUMA_LEVELS; k++) begin
      if (scaled >= SCALED_W'(k * LUMA_DIVISOR)) begin
        lvl = lvl + GLYPH_W'(1);
      end
    end
    return lvl;
  endfunction

endpackage

[rtl/segc_if.sv]
interface segc_pix_if import segc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_top_left;
  logic [PIX_W-1:0] pix_top;
  logic [PIX_W-1:0] pix_top_right;
  logic [PIX_W-1:0] pix_left;
  logic [PIX_W-1:0] pix_centre;
  logic [PIX_W-1:0] pix_right;
  logic [PIX_W-1:0] pix_bottom_left;
  logic [PIX_W-1:0] pix_bottom;
  logic [PIX_W-1:0] pix_bottom_right;
  logic             on_border;

  modport source (
    output valid, pix_top_left, pix_top, pix_top_right, pix_left, pix_centre,
           pix_right, pix_bottom_left, pix_bottom, pix_bottom_right, on_border,
    input  ready
  );
  modport sink (
    input  valid, pix_top_left, pix_top, pix_top_right, pix_left, pix_centre,
           pix_right, pix_bottom_left, pix_bottom, pix_bottom_right, on_border,
    output ready
  );
endinterface

interface segc_res_if import segc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GLYPH_W-1:0] glyph_index;
  logic               edge_found;

  modport source (output valid, glyph_index, edge_found, input ready);
  modport sink (input valid, glyph_index, edge_found, output ready);
endinterface

interface segc_cfg_if import segc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/segc_front.sv]
// Sobel gradients, their magnitudes and signs, the luminance level and the
// dark/interior qualification of one window.
module segc_front import segc_pkg::*; (
  input  window_t           win,
  input  logic [DARK_W-1:0] dark_limit,
  output front_t            front
);

  logic [SUM_W-1:0]         pos_x, neg_x, pos_y, neg_y;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [GRAD_W-1:0] abs_x, abs_y;

  assign pos_x = SUM_W'(win.top_right) + {1'b0, win.right, 1'b0} + SUM_W'(win.bottom_right);
  assign neg_x = SUM_W'(win.top_left) + {1'b0, win.left, 1'b0} + SUM_W'(win.bottom_left);
  assign pos_y = SUM_W'(win.bottom_left) + {1'b0, win.bottom, 1'b0}
               + SUM_W'(win.bottom_right);
  assign neg_y = SUM_W'(win.top_left) + {1'b0, win.top, 1'b0} + SUM_W'(win.top_right);

  assign gx = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
  assign gy = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});

  assign abs_x = gx[GRAD_W-1] ? -gx : gx;
  assign abs_y = gy[GRAD_W-1] ? -gy : gy;

  always_comb begin
    front.mag_x        = abs_x[MAG_W-1:0];
    front.mag_y        = abs_y[MAG_W-1:0];
    front.side.luma    = luma_level(win.centre);
    front.side.qual    = !win.on_border && ({1'b0, win.centre} < dark_limit);
    front.side.gx_neg  = gx[GRAD_W-1];
    front.side.gy_neg  = gy[GRAD_W-1];
    front.side.gx_zero = (pos_x == neg_x);
    front.side.gy_zero = (pos_y == neg_y);
  end

endmodule

[rtl/sobel_edge_glyph_classifier.sv]
// An accepted window moves through the stage 1 to 4 registers into the output
// register, which presents its result and holds it while the result side stalls.
// Throughput: one window per cycle unless the result side stalls; five register
// stages, none with over one layer of multipliers of at most 20 by 20 bits,
// output register last. Reset (rst, synchronous, active high) empties the
// pipeline and restores edge_limit to 400 and dark_limit to 96.
module sobel_edge_glyph_classifier import segc_pkg::*; (
  input logic         clk,
  input logic         rst,
  segc_pix_if.sink    pix,
  segc_res_if.source  res,
  segc_cfg_if.sink    cfg
);

  // Config registers, read live by the stages; an unknown index is dropped.
  // The user must write them only while the pipeline is empty; not enforced.
  logic [LIM_W-1:0]  edge_limit;
  logic [DARK_W-1:0] dark_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_limit <= EDGE_LIMIT_RESET;
      dark_limit <= DARK_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_EDGE_LIMIT: edge_limit <= cfg.data[LIM_W-1:0];
        REG_DARK_LIMIT: dark_limit <= cfg.data[DARK_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage advances when it is empty or when the stage after it can
  // take its contents, so bubbles are squeezed out and a stalled output
  // register does not stop the earlier stages from filling.
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5 || res.ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign pix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= pix.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  // Stage 1: gradients, magnitudes, signs and the luminance level.
  window_t win;
  front_t  front;
  front_t  s1;

  always_comb begin
    win.top_left     = pix.pix_top_left;
    win.top          = pix.pix_top;
    win.top_right    = pix.pix_top_right;
    win.left         = pix.pix_left;
    win.centre       = pix.pix_centre;
    win.right        = pix.pix_right;
    win.bottom_left  = pix.pix_bottom_left;
    win.bottom       = pix.pix_bottom;
    win.bottom_right = pix.pix_bottom_right;
    win.on_border    = pix.on_border;
  end

  segc_front u_front (
    .win        (win),
    .dark_limit (dark_limit),
    .front      (front)
  );

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1 <= front;
    end
  end

  // Stage 2: squares of both magnitudes and of the edge limit.
  side_t              side2;
  logic [SQ_W-1:0]    a2, b2;
  logic [LIMSQ_W-1:0] lim2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      side2 <= s1.side;
      a2    <= SQ_W'(s1.mag_x) * SQ_W'(s1.mag_x);
      b2    <= SQ_W'(s1.mag_y) * SQ_W'(s1.mag_y);
      lim2  <= LIMSQ_W'(edge_limit) * LIMSQ_W'(edge_limit);
    end
  end

  // Stage 3: the magnitude test against the limit, and the differences
  // that feed the exact tan72 and tan18 comparisons. A tie on the limit
  // counts as an edge only for a non-negative Gx.
  logic [SUMSQ_W-1:0]   sum_sq;
  logic [FIVE_SQ_W-1:0] a2x5;
  logic [FIVE_SQ_W-1:0] d_wide;
  logic [SQ_W-1:0]      f_wide;

  side_t             side3;
  logic              edge3, above_pre3, below_pre3;
  logic [SQ_W-1:0]   d3, f3;
  logic [QUAD_W-1:0] a4_3;

  assign sum_sq = SUMSQ_W'(a2) + SUMSQ_W'(b2);
  assign a2x5   = (FIVE_SQ_W'(a2) << 2) + FIVE_SQ_W'(a2);
  assign d_wide = FIVE_SQ_W'(b2) - a2x5;
  assign f_wide = a2 - b2;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      side3      <= side2;
      edge3      <= (LIMSQ_W'(sum_sq) > lim2)
                 || ((LIMSQ_W'(sum_sq) == lim2) && !side2.gx_neg);
      above_pre3 <= FIVE_SQ_W'(b2) > a2x5;
      below_pre3 <= b2 < a2;
      d3         <= d_wide[SQ_W-1:0];
      f3         <= f_wide;
      a4_3       <= QUAD_W'(a2) * QUAD_W'(a2);
    end
  end

  // Stage 4: squares of the differences and the scaled fourth power.
  // Gy/Gx > tan72 when (b2 - 5a2)^2 > 20a^4; Gy/Gx < tan18 when
  // 5(a2 - b2)^2 > 4a^4.
  logic [QUAD_W-1:0] ff;
  side_t             side4;
  logic              edge4, above_pre4, below_pre4;
  logic [WIDE_W-1:0] dd4, ff5_4, a4x20_4, a4x4_4;

  assign ff = QUAD_W'(f3) * QUAD_W'(f3);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      side4      <= side3;
      edge4      <= edge3;
      above_pre4 <= above_pre3;
      below_pre4 <= below_pre3;
      dd4        <= WIDE_W'(QUAD_W'(d3) * QUAD_W'(d3));
      ff5_4      <= (WIDE_W'(ff) << 2) + WIDE_W'(ff);
      a4x20_4    <= (WIDE_W'(a4_3) << 4) + (WIDE_W'(a4_3) << 2);
      a4x4_4     <= WIDE_W'(a4_3) << 2;
    end
  end

  // Stage 5: direction bin and final choice, into the output register.
  logic               above, below;
  logic [GLYPH_W-1:0] dir_glyph;
  logic [GLYPH_W-1:0] glyph5;
  logic               found5;

  assign above = above_pre4 && (dd4 > a4x20_4);
  assign below = below_pre4 && (ff5_4 > a4x4_4);

  always_comb begin
    if (side4.gx_zero) begin
      // A zero Gx stands for a tiny positive value.
      dir_glyph = side4.gy_zero ? GLYPH_VERTICAL : GLYPH_HORIZONTAL;
    end else if (above) begin
      dir_glyph = GLYPH_HORIZONTAL;
    end else if (side4.gy_zero || below) begin
      dir_glyph = GLYPH_VERTICAL;
    end else if (side4.gx_neg != side4.gy_neg) begin
      dir_glyph = GLYPH_BACKSLASH;
    end else begin
      dir_glyph = GLYPH_SLASH;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      found5 <= side4.qual && edge4;
      glyph5 <= (side4.qual && edge4) ? dir_glyph : side4.luma;
    end
  end

  assign res.valid       = v5;
  assign res.glyph_index = glyph5;
  assign res.edge_found  = found5;

`ifndef SYNTH
  a_found_matches_glyph: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.edge_found == (res.glyph_index >= GLYPH_HORIZONTAL)))
    else $error("edge_found disagrees with the glyph class");

  a_glyph_in_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.glyph_index <= GLYPH_SLASH))
    else $error("glyph index beyond the last edge glyph");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res.valid)
    else $error("result presented straight after reset");

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && v5 && !res.ready) |-> !pix.ready)
    else $error("window taken while every stage is held");

  a_empty_front_accepts: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> pix.ready)
    else $error("input refused with an empty first stage");
`endif

endmodule
